// ===== hdl/gapdec_pkg.sv =====
package gapdec_pkg;

  localparam int WORD_BITS          = 32;
  localparam int BUF_BITS           = 64;
  localparam int FILL_W             = 7;
  localparam int MAX_RESULTS        = 16;
  localparam int DEF_MAX_VALUE_BITS = 16;
  localparam int MOD_STEPS          = WORD_BITS + 1;
  localparam int MOD_CNT_W          = $clog2(MOD_STEPS + 1);

  localparam logic [WORD_BITS-1:0] MODULUS_RESET = WORD_BITS'(1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_WORD  = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_STEP  = 7'b0000100,
    ST_ADD   = 7'b0001000,
    ST_CHECK = 7'b0010000,
    ST_MOD   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_CODE = 2'd1,
    CLS_ERR  = 2'd2
  } code_class_t;

endpackage

// ===== hdl/run_length_gamma_gap_decoder_top.sv =====
// Start word: accepted while idle; a zero entry count goes to the emit state, which registers its result.
// Stream word: loaded into the bit buffer, then each code passes the scan, step, add, check and emit states,
// plus the mod state when the sum reaches the modulus and the bit-serial remainder unit runs.
// Up to 16 results per word; the input is held off until the word's last result is registered.
// Reset (rst, synchronous, active high) clears all control state, sets modulus to 1 and
// leaves the decoder finished until a start word arrives.
module run_length_gamma_gap_decoder_top #(
  parameter int MAX_VALUE_BITS = gapdec_pkg::DEF_MAX_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] stream_word,
  input  logic [31:0] start_value,
  input  logic [31:0] entry_count,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_value,
  output logic        is_run,
  output logic [15:0] step_size,
  output logic [31:0] phi_value,
  output logic [31:0] entries_done,
  output logic        reached_count,
  output logic        format_error,
  output logic        last
);

  localparam int LIMIT = MAX_VALUE_BITS - 1;
  localparam int ZW    = $clog2(MAX_VALUE_BITS);
  localparam int LW    = ZW + 2;
  localparam int KW    = $clog2(gapdec_pkg::MAX_RESULTS);
  localparam int FW    = gapdec_pkg::FILL_W;
  localparam int BB    = gapdec_pkg::BUF_BITS;
  localparam int WB    = gapdec_pkg::WORD_BITS;

  gapdec_pkg::state_t state;

  logic [31:0]     modulus;
  logic [BB-1:0]   bit_buffer;
  logic [FW-1:0]   buffer_fill;
  logic [31:0]     running_value;
  logic [31:0]     entries_consumed;
  logic [31:0]     entries_wanted;
  logic            finished;

  logic [KW-1:0]   k;
  logic [MAX_VALUE_BITS-1:0] v_reg;
  logic [31:0]     addend;
  logic [32:0]     sum;
  logic [gapdec_pkg::MOD_CNT_W-1:0] mod_cnt;

  logic [15:0]     res_value;
  logic            res_run;
  logic [15:0]     res_step;
  logic            res_reached;
  logic            res_error;

  logic [ZW-1:0]   lz;
  logic [LW-1:0]   code_len;
  logic [BB-1:0]   shifted;
  logic [MAX_VALUE_BITS-1:0] v_top;
  logic [MAX_VALUE_BITS-1:0] v_now;
  logic [ZW-1:0]   v_shamt;
  gapdec_pkg::code_class_t cls;

  logic [32:0]     m_eff;
  logic [MAX_VALUE_BITS-1:0] step_w;
  logic [32:0]     step_sum;
  logic [32:0]     inc_sum;
  logic [32:0]     trial;
  logic [32:0]     trial_red;
  logic [BB-1:0]   base_buf;
  logic [FW-1:0]   base_fill;
  logic            more;
  logic            out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != gapdec_pkg::ST_IDLE);
  assign m_eff     = (modulus == 32'd0) ? {1'b1, 32'd0} : {1'b0, modulus};
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    lz = ZW'(LIMIT);
    for (int i = LIMIT - 1; i >= 0; i--) begin
      if (bit_buffer[BB-1-i]) begin
        lz = ZW'(i);
      end
    end
  end

  assign code_len = {1'b0, lz, 1'b0} + LW'(2);
  assign shifted  = bit_buffer << lz;
  assign v_top    = shifted[BB-1 -: MAX_VALUE_BITS];
  assign v_shamt  = ZW'(MAX_VALUE_BITS - 2) - lz;
  assign v_now    = v_top >> v_shamt;

  always_comb begin
    if (lz == ZW'(LIMIT) && buffer_fill >= FW'(LIMIT)) begin
      cls = gapdec_pkg::CLS_ERR;
    end else if (lz != ZW'(LIMIT) && FW'(code_len) <= buffer_fill) begin
      cls = gapdec_pkg::CLS_CODE;
    end else begin
      cls = gapdec_pkg::CLS_NONE;
    end
  end

  assign more = !finished && (k != KW'(gapdec_pkg::MAX_RESULTS - 1))
                && (cls != gapdec_pkg::CLS_NONE);

  assign step_w   = v_reg[0] ? (v_reg >> 1) + MAX_VALUE_BITS'(1) : (v_reg >> 1);
  assign step_sum = {1'b0, entries_consumed} + 33'(step_w);
  assign inc_sum  = {1'b0, entries_consumed} + 33'd1;

  assign trial     = {running_value, sum[32]};
  assign trial_red = (trial >= m_eff) ? trial - m_eff : trial;

  assign base_buf  = (buffer_fill > FW'(BB - WB)) ? '0 : bit_buffer;
  assign base_fill = (buffer_fill > FW'(BB - WB)) ? '0 : buffer_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= gapdec_pkg::MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= gapdec_pkg::ST_IDLE;
      bit_buffer       <= '0;
      buffer_fill      <= '0;
      running_value    <= '0;
      entries_consumed <= '0;
      entries_wanted   <= '0;
      finished         <= 1'b1;
      k                <= '0;
      mod_cnt          <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != gapdec_pkg::ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        gapdec_pkg::ST_IDLE: begin
          if (in_valid) begin
            k <= '0;
            if (opcode == gapdec_pkg::OP_START) begin
              bit_buffer       <= '0;
              buffer_fill      <= '0;
              running_value    <= start_value;
              entries_consumed <= '0;
              entries_wanted   <= entry_count;
              finished         <= (entry_count == 32'd0);
              if (entry_count == 32'd0) begin
                res_value   <= '0;
                res_run     <= 1'b0;
                res_step    <= '0;
                res_reached <= 1'b1;
                res_error   <= 1'b0;
                state       <= gapdec_pkg::ST_EMIT;
              end
            end else if (!finished) begin
              bit_buffer  <= base_buf | ({stream_word, WB'(0)} >> base_fill);
              buffer_fill <= base_fill + FW'(WB);
              state       <= gapdec_pkg::ST_SCAN;
            end
          end
        end
        gapdec_pkg::ST_SCAN: begin
          unique case (cls)
            gapdec_pkg::CLS_ERR: begin
              res_value   <= '0;
              res_run     <= 1'b0;
              res_step    <= '0;
              res_reached <= 1'b0;
              res_error   <= 1'b1;
              finished    <= 1'b1;
              state       <= gapdec_pkg::ST_EMIT;
            end
            gapdec_pkg::CLS_CODE: begin
              v_reg       <= v_now;
              bit_buffer  <= bit_buffer << code_len;
              buffer_fill <= buffer_fill - FW'(code_len);
              state       <= gapdec_pkg::ST_STEP;
            end
            default: begin
              state <= gapdec_pkg::ST_IDLE;
            end
          endcase
        end
        gapdec_pkg::ST_STEP: begin
          res_value <= 16'(v_reg);
          res_run   <= !v_reg[0];
          res_step  <= 16'(step_w);
          res_error <= 1'b0;
          if (!v_reg[0]) begin
            if (step_sum >= {1'b0, entries_wanted}) begin
              addend           <= entries_wanted - entries_consumed;
              entries_consumed <= entries_wanted;
              finished         <= 1'b1;
              res_reached      <= 1'b1;
            end else begin
              addend           <= 32'(step_w);
              entries_consumed <= step_sum[31:0];
              res_reached      <= 1'b0;
            end
          end else begin
            addend           <= 32'(step_w);
            entries_consumed <= inc_sum[31:0];
            finished         <= (inc_sum >= {1'b0, entries_wanted});
            res_reached      <= (inc_sum >= {1'b0, entries_wanted});
          end
          state <= gapdec_pkg::ST_ADD;
        end
        gapdec_pkg::ST_ADD: begin
          sum   <= {1'b0, running_value} + {1'b0, addend};
          state <= gapdec_pkg::ST_CHECK;
        end
        gapdec_pkg::ST_CHECK: begin
          if (sum < m_eff) begin
            running_value <= sum[31:0];
            state         <= gapdec_pkg::ST_EMIT;
          end else begin
            running_value <= '0;
            mod_cnt       <= gapdec_pkg::MOD_CNT_W'(gapdec_pkg::MOD_STEPS);
            state         <= gapdec_pkg::ST_MOD;
          end
        end
        gapdec_pkg::ST_MOD: begin
          running_value <= trial_red[31:0];
          sum           <= sum << 1;
          mod_cnt       <= mod_cnt - gapdec_pkg::MOD_CNT_W'(1);
          if (mod_cnt == gapdec_pkg::MOD_CNT_W'(1)) begin
            state <= gapdec_pkg::ST_EMIT;
          end
        end
        gapdec_pkg::ST_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            code_value    <= res_value;
            is_run        <= res_run;
            step_size     <= res_step;
            phi_value     <= running_value;
            entries_done  <= entries_consumed;
            reached_count <= res_reached;
            format_error  <= res_error;
            last          <= !more;
            if (more) begin
              k     <= k + KW'(1);
              state <= gapdec_pkg::ST_SCAN;
            end else begin
              state <= gapdec_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state <= gapdec_pkg::ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entries_consumed <= entries_wanted)
    else $error("entries consumed beyond entry count");

  a_fill_even: assert property (@(posedge clk) disable iff (rst)
    !buffer_fill[0] && buffer_fill <= FW'(BB))
    else $error("buffer fill out of range");

  a_err_not_final: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(format_error && reached_count))
    else $error("format error word flagged as final");

  a_mod_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == gapdec_pkg::ST_MOD && mod_cnt == gapdec_pkg::MOD_CNT_W'(1))
    |=> ({1'b0, running_value} < m_eff))
    else $error("remainder not below modulus");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   MAXV           = gapdec_pkg::DEF_MAX_VALUE_BITS;
  localparam int   SETTLE_CYCLES  = 64;
  localparam int   WATCHDOG_LIMIT = 4000;
  localparam logic OP_START       = gapdec_pkg::OP_START;
  localparam logic OP_WORD        = gapdec_pkg::OP_WORD;

  typedef struct packed {
    logic        op;
    logic [31:0] word;
    logic [31:0] base;
    logic [31:0] count;
  } gap_item_t;

  typedef struct packed {
    logic [15:0] val;
    logic        run;
    logic [15:0] stride;
    logic [31:0] phi;
    logic [31:0] used;
    logic        reached;
    logic        ferr;
    logic        lst;
  } gap_res_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    gap_item_t it;
    gap_res_t  res;
  } stim_row_t;

  localparam gap_res_t NO_RES = '0;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = OP_START;
  logic [31:0] stream_word = '0;
  logic [31:0] start_value = '0;
  logic [31:0] entry_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] code_value;
  logic        is_run;
  logic [15:0] step_size;
  logic [31:0] phi_value;
  logic [31:0] entries_done;
  logic        reached_count;
  logic        format_error;
  logic        last;

  logic [63:0] dec_buf  = '0;
  int          dec_fill = 0;
  logic [31:0] dec_phi  = '0;
  logic [31:0] dec_used = '0;
  logic [31:0] dec_want = '0;
  logic        dec_halt = 1'b1;
  logic [31:0] dec_mod  = gapdec_pkg::MODULUS_RESET;

  gap_res_t  gaps_due[$];
  bit        code_bits[$];
  stim_row_t dir_rows[$];
  int        bad_results = 0;
  int        send_pct = 0;
  int        stall_pct = 0;
  int        idle_cycles = 0;
  gap_res_t  seen;
  gap_res_t  want;

  run_length_gamma_gap_decoder_top i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .stream_word(stream_word),
    .start_value(start_value),
    .entry_count(entry_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .code_value(code_value),
    .is_run(is_run),
    .step_size(step_size),
    .phi_value(phi_value),
    .entries_done(entries_done),
    .reached_count(reached_count),
    .format_error(format_error),
    .last(last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [31:0] mod_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    logic [32:0] m;
    sum = {1'b0, a} + {1'b0, b};
    m = (dec_mod == 32'd0) ? 33'h1_0000_0000 : {1'b0, dec_mod};
    return 32'(sum % m);
  endfunction

  function automatic int decode_item(input gap_item_t it, ref gap_res_t q[$]);
    int          nres;
    int          z;
    int          len;
    logic [31:0] v;
    logic [31:0] stride;
    nres = 0;
    if (it.op == OP_START) begin
      dec_buf  = '0;
      dec_fill = 0;
      dec_phi  = it.base;
      dec_used = '0;
      dec_want = it.count;
      dec_halt = (it.count == 32'd0);
      if (dec_halt) begin
        q.push_back('{16'd0, 1'b0, 16'd0, dec_phi, 32'd0, 1'b1, 1'b0, 1'b1});
        nres = 1;
      end
      return nres;
    end
    if (dec_halt) return 0;
    if (dec_fill > 64 - gapdec_pkg::WORD_BITS) begin
      dec_buf  = '0;
      dec_fill = 0;
    end
    dec_buf  = dec_buf | ({it.word, 32'd0} >> dec_fill);
    dec_fill = dec_fill + gapdec_pkg::WORD_BITS;
    while (nres < gapdec_pkg::MAX_RESULTS && !dec_halt) begin
      z = 0;
      while (z < MAXV - 1 && z < dec_fill && !dec_buf[63 - z]) z++;
      if (z >= MAXV - 1) begin
        q.push_back('{16'd0, 1'b0, 16'd0, dec_phi, dec_used, 1'b0, 1'b1, 1'b0});
        nres++;
        dec_halt = 1'b1;
        break;
      end
      if (z >= dec_fill) break;
      len = 2 * z + 2;
      if (len > dec_fill) break;
      v        = 32'(dec_buf >> (64 - len));
      dec_buf  = dec_buf << len;
      dec_fill = dec_fill - len;
      if (!v[0]) begin
        stride = v >> 1;
        if ({1'b0, dec_used} + {1'b0, stride} >= {1'b0, dec_want}) begin
          dec_phi  = mod_add(dec_phi, dec_want - dec_used);
          dec_used = dec_want;
          dec_halt = 1'b1;
        end else begin
          dec_phi  = mod_add(dec_phi, stride);
          dec_used = dec_used + stride;
        end
        q.push_back('{v[15:0], 1'b1, stride[15:0], dec_phi, dec_used, dec_halt, 1'b0, 1'b0});
      end else begin
        stride   = (v + 32'd1) >> 1;
        dec_phi  = mod_add(dec_phi, stride);
        dec_used = dec_used + 32'd1;
        if (dec_used >= dec_want) dec_halt = 1'b1;
        q.push_back('{v[15:0], 1'b0, stride[15:0], dec_phi, dec_used, dec_halt, 1'b0, 1'b0});
      end
      nres++;
    end
    if (nres > 0) q[q.size() - 1].lst = 1'b1;
    return nres;
  endfunction

  function automatic logic [31:0] next_stream_word();
    int          z;
    logic [15:0] v;
    logic [31:0] w;
    while (code_bits.size() < 32) begin
      z = ($urandom_range(9) == 0) ? $urandom_range(14, 4) : $urandom_range(3, 0);
      v = 16'($urandom);
      v[z + 1] = 1'b1;
      repeat (z) code_bits.push_back(1'b0);
      for (int i = z + 1; i >= 0; i--) code_bits.push_back(v[i]);
    end
    for (int i = 31; i >= 0; i--) w[i] = code_bits.pop_front();
    return w;
  endfunction

  function automatic string res_str(gap_res_t r);
    return $sformatf("val=%h run=%b step=%h phi=%h done=%h reached=%b ferr=%b last=%b",
                     r.val, r.run, r.stride, r.phi, r.used, r.reached, r.ferr, r.lst);
  endfunction

  task automatic write_modulus(input logic [31:0] m);
    in_valid <= 1'b0;
    while (gaps_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dec_mod = m;
  endtask

  task automatic send_item(input gap_item_t it, input bit typed, input gap_res_t res,
                           output bit live);
    int       gap;
    gap_res_t scratch[$];
    gap = 0;
    while ($urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= it.op;
    stream_word <= it.word;
    start_value <= it.base;
    entry_count <= it.count;
    do @(posedge clk); while (in_stall);
    live = !(it.op == OP_WORD && dec_halt);
    if (typed) begin
      void'(decode_item(it, scratch));
      gaps_due.push_back(res);
    end else begin
      void'(decode_item(it, gaps_due));
    end
  endtask

  task automatic random_phase(input int send_p, input int stall_p, input logic [31:0] m,
                              input int target);
    int          live_items;
    int          nwords;
    int          pick;
    bit          live;
    logic [31:0] base;
    logic [31:0] count;
    gap_item_t   it;
    write_modulus(m);
    send_pct   = send_p;
    stall_pct  = stall_p;
    live_items = 0;
    while (live_items < target) begin
      if ($urandom_range(99) < 8) begin
        it = '{OP_WORD, $urandom, $urandom, $urandom};
        send_item(it, 1'b0, NO_RES, live);
        live_items += int'(live);
      end else begin
        pick  = $urandom_range(99);
        count = (pick < 6) ? 32'd0 : (pick < 18) ? $urandom : $urandom_range(48, 1);
        base  = ($urandom_range(99) < 15 || dec_mod == 32'd0) ? $urandom
                                                               : $urandom % dec_mod;
        it = '{OP_START, $urandom, base, count};
        code_bits.delete();
        send_item(it, 1'b0, NO_RES, live);
        live_items++;
        nwords = $urandom_range(6, 1);
        for (int i = 0; i < nwords; i++) begin
          if (dec_halt && $urandom_range(3) != 0) break;
          it = '{OP_WORD, ($urandom_range(99) < 8) ? $urandom : next_stream_word(),
                 $urandom, $urandom};
          send_item(it, 1'b0, NO_RES, live);
          live_items += int'(live);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = {code_value, is_run, step_size, phi_value, entries_done, reached_count,
              format_error, last};
      if (gaps_due.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) $display("unexpected result: %s", res_str(seen));
      end else begin
        want = gaps_due.pop_front();
        if (seen.val !== want.val || seen.run !== want.run || seen.stride !== want.stride ||
            seen.phi !== want.phi || seen.used !== want.used ||
            seen.reached !== want.reached || seen.ferr !== want.ferr ||
            seen.lst !== want.lst) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("mismatch: expected %s", res_str(want));
            $display("          actual   %s", res_str(seen));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[run_length_gamma_gap_decoder_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    bit        live;
    // reset modulus is one
    dir_rows.push_back('{ROW_TYPED, '{OP_START, 32'h0, 32'd5, 32'd0},
                         '{16'd0, 1'b0, 16'd0, 32'd5, 32'd0, 1'b1, 1'b0, 1'b1}});
    dir_rows.push_back('{ROW_ITEM, '{OP_WORD, 32'hFFFF_FFFF, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_START, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, NO_RES});
    dir_rows.push_back('{ROW_TYPED, '{OP_WORD, 32'h0001_0000, 32'h0, 32'h0},
                         '{16'd0, 1'b0, 16'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b1, 1'b1}});
    // modulus zero wraps at 32 bits
    dir_rows.push_back('{ROW_CFG, '{OP_WORD, 32'h0, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_START, 32'h0, 32'hFFFF_FFF0, 32'hFFFF_FFFF}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_WORD, 32'hFFFF_FFFF, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_WORD, 32'h0003_FFFF, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_WORD, 32'h0003_FFFB, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_WORD, 32'hAAAA_AAAA, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_WORD, 32'hAAAA_AAA8, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_WORD, 32'h2FFF_FFFF, 32'h0, 32'h0}, NO_RES});
    // run cut short by the count, start at and above the modulus
    dir_rows.push_back('{ROW_CFG, '{OP_WORD, 32'hFFFF_FFFF, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_START, 32'h0, 32'hFFFF_FFFE, 32'd3}, NO_RES});
    dir_rows.push_back('{ROW_TYPED, '{OP_WORD, 32'h20FF_FFFF, 32'h0, 32'h0},
                         '{16'd8, 1'b1, 16'd4, 32'd2, 32'd3, 1'b1, 1'b0, 1'b1}});
    dir_rows.push_back('{ROW_ITEM, '{OP_WORD, 32'hFFFF_FFFF, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_START, 32'h0, 32'hFFFF_FFFF, 32'd2}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_WORD, 32'hFFFF_FFFF, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_CFG, '{OP_WORD, 32'd7, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_START, 32'h0, 32'd100, 32'd5}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_WORD, 32'hFFFF_FFFF, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_START, 32'h0, 32'd3, 32'd1000}, NO_RES});
    dir_rows.push_back('{ROW_TYPED, '{OP_WORD, 32'h0, 32'h0, 32'h0},
                         '{16'd0, 1'b0, 16'd0, 32'd3, 32'd0, 1'b0, 1'b1, 1'b1}});
    // incomplete code held across words
    dir_rows.push_back('{ROW_ITEM, '{OP_START, 32'h0, 32'd0, 32'd100}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_WORD, 32'hFFFF_FFF0, 32'h0, 32'h0}, NO_RES});
    dir_rows.push_back('{ROW_ITEM, '{OP_WORD, 32'h7FFF_FFFF, 32'h0, 32'h0}, NO_RES});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        write_modulus(row.it.word);
      end else begin
        send_item(row.it, row.kind == ROW_TYPED, row.res, live);
      end
    end

    random_phase(0, 0, 32'd1, 35);
    random_phase(48, 0, $urandom_range(50, 2), 35);
    random_phase(0, 48, 32'hFFFF_FFFF, 35);
    random_phase(32, 32, $urandom_range(100000, 1000), 35);

    in_valid <= 1'b0;
    while (gaps_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_results == 0 && gaps_due.size() == 0) begin
      $display("[run_length_gamma_gap_decoder_top] OK");
    end else begin
      $display("[run_length_gamma_gap_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
